// ----- sv/i2cm_pkg.sv -----
package i2cm_pkg;

    localparam int DelayW  = 8;
    localparam int ByteW   = 8;
    localparam int KindW   = 3;
    localparam int BitCntW = 4;
    localparam int InDataW = 16;
    localparam int OutDataW = 16;

    localparam logic [ByteW-1:0]   MsbMask  = 8'h80;
    localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

    typedef enum logic [KindW-1:0] {
        K_TICK  = 3'd0,
        K_START = 3'd1,
        K_WRITE = 3'd2,
        K_READ  = 3'd3,
        K_STOP  = 3'd4
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'd0,
        ST_S_SCLH  = 5'd1,
        ST_S_SDAL  = 5'd2,
        ST_W_SCLL0 = 5'd3,
        ST_W_SDA   = 5'd4,
        ST_W_SCLH  = 5'd5,
        ST_W_SCLL  = 5'd6,
        ST_W_REL   = 5'd7,
        ST_W_ASCLH = 5'd8,
        ST_W_SAMP  = 5'd9,
        ST_W_ASCLL = 5'd10,
        ST_R_SCLH  = 5'd11,
        ST_R_SAMP  = 5'd12,
        ST_R_SCLL  = 5'd13,
        ST_R_ACK   = 5'd14,
        ST_R_ASCLH = 5'd15,
        ST_R_ASCLL = 5'd16,
        ST_R_REL   = 5'd17,
        ST_P_SDAL  = 5'd18,
        ST_P_SCLH  = 5'd19,
        ST_P_REL   = 5'd20
    } t_step;

    typedef struct packed {
        logic             rejected;
        logic [ByteW-1:0] read_data;
        logic             ack_seen;
        logic             done;
        logic             busy;
        logic             sda_low;
        logic             scl_level;
    } t_result;

endpackage

// ----- sv/i2cm_seq.sv -----
module i2cm_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [i2cm_pkg::KindW-1:0]      i_kind,
    input  logic [i2cm_pkg::ByteW-1:0]      i_data_byte,
    input  logic                            i_last_byte,
    input  logic                            i_sda_in,
    input  logic [i2cm_pkg::DelayW-1:0]     i_scl_gap,
    output i2cm_pkg::t_result               o_res
);

    i2cm_pkg::t_step                 r_step,  n_step;
    i2cm_pkg::t_kind                 r_op,    n_op;
    logic [i2cm_pkg::ByteW-1:0]      r_shift, n_shift;
    logic [i2cm_pkg::BitCntW-1:0]    r_bits,  n_bits;
    logic [i2cm_pkg::DelayW-1:0]     r_dly,   n_dly;
    logic                            r_scl,   n_scl;
    logic                            r_sda,   n_sda;
    logic                            r_ack,   n_ack;
    logic                            r_last,  n_last;

    logic                            scl_ok;
    logic                            is_cmd;
    logic                            fin;
    logic [i2cm_pkg::BitCntW-1:0]    bits_inc;

    assign is_cmd = (i_kind == i2cm_pkg::K_START) || (i_kind == i2cm_pkg::K_WRITE) ||
                    (i_kind == i2cm_pkg::K_READ)  || (i_kind == i2cm_pkg::K_STOP);
    assign scl_ok   = (r_dly >= i_scl_gap);
    assign bits_inc = r_bits + 1'b1;

    always_comb begin
        n_step  = r_step;
        n_op    = r_op;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_dly   = r_dly;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_last  = r_last;
        fin     = 1'b0;
        o_res   = '0;

        if (is_cmd) begin
            if (r_step != i2cm_pkg::ST_IDLE) begin
                o_res.rejected = 1'b1;
            end else begin
                n_op   = i2cm_pkg::t_kind'(i_kind);
                n_dly  = '0;
                n_bits = '0;
                n_ack  = 1'b0;
                n_last = i_last_byte;
                case (i_kind)
                    i2cm_pkg::K_START: begin
                        n_shift = i_data_byte;
                        n_step  = i2cm_pkg::ST_S_SCLH;
                    end
                    i2cm_pkg::K_WRITE: begin
                        n_shift = i_data_byte;
                        n_step  = i2cm_pkg::ST_W_SCLL0;
                    end
                    i2cm_pkg::K_READ: begin
                        n_shift = '0;
                        n_step  = i2cm_pkg::ST_R_SCLH;
                    end
                    default: n_step = i2cm_pkg::ST_P_SDAL;
                endcase
            end
        end else if (r_step != i2cm_pkg::ST_IDLE) begin
            // every SCL edge waits out the programmed delay first
            case (r_step)
                i2cm_pkg::ST_S_SCLH, i2cm_pkg::ST_W_SCLL0, i2cm_pkg::ST_W_SCLH,
                i2cm_pkg::ST_W_SCLL, i2cm_pkg::ST_W_ASCLH, i2cm_pkg::ST_W_ASCLL,
                i2cm_pkg::ST_R_SCLH, i2cm_pkg::ST_R_SCLL, i2cm_pkg::ST_R_ASCLH,
                i2cm_pkg::ST_R_ASCLL, i2cm_pkg::ST_P_SCLH: begin
                    n_dly = scl_ok ? '0 : r_dly + 1'b1;
                end
                default: ;
            endcase

            case (r_step)
                i2cm_pkg::ST_S_SCLH: if (scl_ok) begin
                    n_scl  = 1'b1;
                    n_step = i2cm_pkg::ST_S_SDAL;
                end
                i2cm_pkg::ST_S_SDAL: begin
                    n_sda  = 1'b1;
                    n_step = i2cm_pkg::ST_W_SCLL0;
                end
                i2cm_pkg::ST_W_SCLL0: if (scl_ok) begin
                    n_scl  = 1'b0;
                    n_bits = '0;
                    n_step = i2cm_pkg::ST_W_SDA;
                end
                i2cm_pkg::ST_W_SDA: begin
                    n_sda  = ~|(r_shift & i2cm_pkg::MsbMask);
                    n_step = i2cm_pkg::ST_W_SCLH;
                end
                i2cm_pkg::ST_W_SCLH: if (scl_ok) begin
                    n_scl  = 1'b1;
                    n_step = i2cm_pkg::ST_W_SCLL;
                end
                i2cm_pkg::ST_W_SCLL: if (scl_ok) begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[i2cm_pkg::ByteW-2:0], 1'b0};
                    n_bits  = bits_inc;
                    n_step  = (bits_inc >= i2cm_pkg::BitsPerByte) ?
                              i2cm_pkg::ST_W_REL : i2cm_pkg::ST_W_SDA;
                end
                i2cm_pkg::ST_W_REL: begin
                    n_sda  = 1'b0;
                    n_step = i2cm_pkg::ST_W_ASCLH;
                end
                i2cm_pkg::ST_W_ASCLH: if (scl_ok) begin
                    n_scl  = 1'b1;
                    n_step = i2cm_pkg::ST_W_SAMP;
                end
                i2cm_pkg::ST_W_SAMP: begin
                    n_ack  = ~i_sda_in;
                    n_step = i2cm_pkg::ST_W_ASCLL;
                end
                i2cm_pkg::ST_W_ASCLL: if (scl_ok) begin
                    n_scl  = 1'b0;
                    n_step = i2cm_pkg::ST_IDLE;
                    fin    = 1'b1;
                end
                i2cm_pkg::ST_R_SCLH: if (scl_ok) begin
                    n_scl  = 1'b1;
                    n_step = i2cm_pkg::ST_R_SAMP;
                end
                i2cm_pkg::ST_R_SAMP: begin
                    n_shift = {r_shift[i2cm_pkg::ByteW-2:0], i_sda_in};
                    n_step  = i2cm_pkg::ST_R_SCLL;
                end
                i2cm_pkg::ST_R_SCLL: if (scl_ok) begin
                    n_scl  = 1'b0;
                    n_bits = bits_inc;
                    n_step = (bits_inc >= i2cm_pkg::BitsPerByte) ?
                             i2cm_pkg::ST_R_ACK : i2cm_pkg::ST_R_SCLH;
                end
                i2cm_pkg::ST_R_ACK: begin
                    n_sda  = ~r_last;
                    n_step = i2cm_pkg::ST_R_ASCLH;
                end
                i2cm_pkg::ST_R_ASCLH: if (scl_ok) begin
                    n_scl  = 1'b1;
                    n_step = i2cm_pkg::ST_R_ASCLL;
                end
                i2cm_pkg::ST_R_ASCLL: if (scl_ok) begin
                    n_scl  = 1'b0;
                    n_step = r_last ? i2cm_pkg::ST_P_SDAL : i2cm_pkg::ST_R_REL;
                end
                i2cm_pkg::ST_R_REL: begin
                    n_sda  = 1'b0;
                    n_step = i2cm_pkg::ST_IDLE;
                    fin    = 1'b1;
                end
                i2cm_pkg::ST_P_SDAL: begin
                    n_sda  = 1'b1;
                    n_step = i2cm_pkg::ST_P_SCLH;
                end
                i2cm_pkg::ST_P_SCLH: if (scl_ok) begin
                    n_scl  = 1'b1;
                    n_step = i2cm_pkg::ST_P_REL;
                end
                i2cm_pkg::ST_P_REL: begin
                    n_sda  = 1'b0;
                    n_step = i2cm_pkg::ST_IDLE;
                    fin    = 1'b1;
                end
                default: n_step = i2cm_pkg::ST_IDLE;
            endcase
        end

        o_res.scl_level = n_scl;
        o_res.sda_low   = n_sda;
        o_res.busy      = (n_step != i2cm_pkg::ST_IDLE);
        o_res.done      = fin;
        if (fin && (r_op == i2cm_pkg::K_START || r_op == i2cm_pkg::K_WRITE)) begin
            o_res.ack_seen = r_ack;
        end
        if (fin && r_op == i2cm_pkg::K_READ) begin
            o_res.read_data = r_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= i2cm_pkg::ST_IDLE;
            r_op    <= i2cm_pkg::K_TICK;
            r_shift <= '0;
            r_bits  <= '0;
            r_dly   <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b0;
            r_ack   <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_accept) begin
            r_step  <= n_step;
            r_op    <= n_op;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_dly   <= n_dly;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_last  <= n_last;
        end
    end

`ifndef SYNTH
    a_rej_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_res.rejected |-> r_step != i2cm_pkg::ST_IDLE)
        else $error("command rejected while idle");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_res.done |=> r_step == i2cm_pkg::ST_IDLE)
        else $error("sequence finished but not idle");
    a_pins_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_scl) && $stable(r_sda) && $stable(r_step))
        else $error("pin state moved without a beat");
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == i2cm_pkg::ST_IDLE |-> !o_res.done)
        else $error("done raised from idle");
`endif

endmodule

// ----- sv/i2cm_obuf.sv -----
module i2cm_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2cm_pkg::t_result   i_res,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cm_pkg::t_result   o_res
);

    logic              r_out_vld;
    logic              r_skid_vld;
    i2cm_pkg::t_result r_out;
    i2cm_pkg::t_result r_skid;
    logic              load_out;

    assign o_ready  = !r_skid_vld;
    assign o_valid  = r_out_vld;
    assign o_res    = r_out;
    assign load_out = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld  <= r_skid_vld || i_valid;
            r_skid_vld <= 1'b0;
        end else if (i_valid && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_vld ? r_skid : i_res;
        end else if (i_valid && !r_skid_vld) begin
            r_skid <= i_res;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid beat held with empty output stage");
`endif

endmodule

// ----- sv/i2c_bit_level_master.sv -----
// Each result beat is registered: into the output register, or via the skid entry.
// One beat per cycle while tready is high; a beat moves the bus at most one step.
// A two-entry output stage (register plus skid) keeps tready registered; the input
// stalls only once both entries hold beats that the receiver has not taken.
// Reset is synchronous, active low: sequencer idle, SCL high, SDA released,
// SCL gap zero, output stage empty.
module i2c_bit_level_master (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [i2cm_pkg::DelayW-1:0]          i_cfg_data,     // SCL gap in ticks
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [i2cm_pkg::InDataW-1:0]         s_axis_tdata,   // data_byte, sda_in
    input  logic [i2cm_pkg::KindW-1:0]           s_axis_tuser,   // kind
    input  logic                                 s_axis_tlast,   // last_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // scl_level, sda_low, busy_res, done_res, ack_seen, read_data, rejected
    output logic [i2cm_pkg::OutDataW-1:0]        m_axis_tdata
);

    logic [i2cm_pkg::DelayW-1:0] r_scl_gap;
    logic                        in_beat;
    i2cm_pkg::t_result           step_res;
    i2cm_pkg::t_result           out_res;

    assign o_cfg_ready = 1'b1;
    assign in_beat     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_gap <= '0;
        end else if (i_cfg_valid) begin
            r_scl_gap <= i_cfg_data;
        end
    end

    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_beat),
        .i_kind      (s_axis_tuser),
        .i_data_byte (s_axis_tdata[i2cm_pkg::ByteW-1:0]),
        .i_last_byte (s_axis_tlast),
        .i_sda_in    (s_axis_tdata[i2cm_pkg::ByteW]),
        .i_scl_gap   (r_scl_gap),
        .o_res       (step_res)
    );

    i2cm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_res   (step_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {{(i2cm_pkg::OutDataW - $bits(i2cm_pkg::t_result)){1'b0}}, out_res};

endmodule

// ----- tb/i2c_bit_level_master_tb.sv -----
`timescale 1ns / 100ps

module i2c_bit_level_master_tb;
    import i2cm_pkg::*;

    localparam int LimitCycles = 300000;
    localparam int ItemBudget  = 1400;
    localparam int HoldCycles  = 300;
    localparam int IdlePct     = 38;
    localparam int SdaLow      = 0;
    localparam int SdaHigh     = 1;
    localparam int SdaRand     = 2;

    typedef struct {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] data;
        logic             last;
        logic             sda;
    } t_bus_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [DelayW-1:0]   i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;     // data_byte, sda_in
    logic [KindW-1:0]    s_axis_tuser = '0;     // kind
    logic                s_axis_tlast = 1'b0;   // last_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // scl_level, sda_low, busy_res, done_res, ack_seen, read_data, rejected
    logic [OutDataW-1:0] m_axis_tdata;

    i2c_bit_level_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // bus sequencer shadow
    t_step              seq_step;
    t_kind              seq_op;
    logic [ByteW-1:0]   seq_shift;
    logic [BitCntW-1:0] seq_bits;
    logic [DelayW-1:0]  seq_wait;
    logic [DelayW-1:0]  scl_gap_shadow;
    logic               seq_scl, seq_sda_low, seq_ack, seq_last;

    t_bus_beat bus_beats_q[$];
    t_result   pin_results_q[$];
    t_bus_beat beat_on_bus;

    bit calm;
    int hold_asked, hold_given, hold_left;
    int sent_beats, working_beats, seq_dones, busy_refusals, checked_beats, mismatches;
    int cycle_cnt;

    function automatic bit scl_due();
        if (seq_wait >= scl_gap_shadow) begin
            seq_wait = '0;
            return 1'b1;
        end
        seq_wait = seq_wait + 1'b1;
        return 1'b0;
    endfunction

    // one pin step; returns 1 when the sequence completes
    function automatic bit bus_advance(logic sda);
        bit fin;
        fin = 1'b0;
        case (seq_step)
            ST_S_SCLH: if (scl_due()) begin
                seq_scl = 1'b1; seq_step = ST_S_SDAL;
            end
            ST_S_SDAL: begin
                seq_sda_low = 1'b1; seq_step = ST_W_SCLL0;
            end
            ST_W_SCLL0: if (scl_due()) begin
                seq_scl = 1'b0; seq_bits = '0; seq_step = ST_W_SDA;
            end
            ST_W_SDA: begin
                seq_sda_low = ((seq_shift & MsbMask) == '0);
                seq_step = ST_W_SCLH;
            end
            ST_W_SCLH: if (scl_due()) begin
                seq_scl = 1'b1; seq_step = ST_W_SCLL;
            end
            ST_W_SCLL: if (scl_due()) begin
                seq_scl = 1'b0;
                seq_shift = seq_shift << 1;
                seq_bits = seq_bits + 1'b1;
                seq_step = (seq_bits >= BitsPerByte) ? ST_W_REL : ST_W_SDA;
            end
            ST_W_REL: begin
                seq_sda_low = 1'b0; seq_step = ST_W_ASCLH;
            end
            ST_W_ASCLH: if (scl_due()) begin
                seq_scl = 1'b1; seq_step = ST_W_SAMP;
            end
            ST_W_SAMP: begin
                seq_ack = ~sda; seq_step = ST_W_ASCLL;
            end
            ST_W_ASCLL: if (scl_due()) begin
                seq_scl = 1'b0; seq_step = ST_IDLE; fin = 1'b1;
            end
            ST_R_SCLH: if (scl_due()) begin
                seq_scl = 1'b1; seq_step = ST_R_SAMP;
            end
            ST_R_SAMP: begin
                seq_shift = {seq_shift[ByteW-2:0], sda};
                seq_step = ST_R_SCLL;
            end
            ST_R_SCLL: if (scl_due()) begin
                seq_scl = 1'b0;
                seq_bits = seq_bits + 1'b1;
                seq_step = (seq_bits >= BitsPerByte) ? ST_R_ACK : ST_R_SCLH;
            end
            ST_R_ACK: begin
                seq_sda_low = ~seq_last; seq_step = ST_R_ASCLH;
            end
            ST_R_ASCLH: if (scl_due()) begin
                seq_scl = 1'b1; seq_step = ST_R_ASCLL;
            end
            ST_R_ASCLL: if (scl_due()) begin
                seq_scl = 1'b0;
                seq_step = seq_last ? ST_P_SDAL : ST_R_REL;
            end
            ST_R_REL: begin
                seq_sda_low = 1'b0; seq_step = ST_IDLE; fin = 1'b1;
            end
            ST_P_SDAL: begin
                seq_sda_low = 1'b1; seq_step = ST_P_SCLH;
            end
            ST_P_SCLH: if (scl_due()) begin
                seq_scl = 1'b1; seq_step = ST_P_REL;
            end
            ST_P_REL: begin
                seq_sda_low = 1'b0; seq_step = ST_IDLE; fin = 1'b1;
            end
            default: seq_step = ST_IDLE;
        endcase
        return fin;
    endfunction

    // returns 1 when the beat did real work (loaded a command or stepped the bus)
    function automatic bit predict_pins(t_bus_beat b, output t_result r);
        bit is_cmd, fin, worked;
        is_cmd = (b.kind >= K_START) && (b.kind <= K_STOP);
        r = '0;
        fin = 1'b0;
        worked = 1'b0;
        if (is_cmd) begin
            if (seq_step != ST_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                worked = 1'b1;
                seq_op = t_kind'(b.kind);
                seq_wait = '0;
                seq_bits = '0;
                seq_ack = 1'b0;
                seq_last = b.last;
                case (seq_op)
                    K_START: begin seq_shift = b.data; seq_step = ST_S_SCLH; end
                    K_WRITE: begin seq_shift = b.data; seq_step = ST_W_SCLL0; end
                    K_READ:  begin seq_shift = '0; seq_step = ST_R_SCLH; end
                    default: seq_step = ST_P_SDAL;
                endcase
            end
        end else if (seq_step != ST_IDLE) begin
            worked = 1'b1;
            fin = bus_advance(b.sda);
        end
        r.done = fin;
        if (fin && (seq_op == K_START || seq_op == K_WRITE))
            r.ack_seen = seq_ack;
        if (fin && seq_op == K_READ)
            r.read_data = seq_shift;
        r.scl_level = seq_scl;
        r.sda_low = seq_sda_low;
        r.busy = (seq_step != ST_IDLE);
        return worked;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch beat %0d: %s got %0h want %0h", checked_beats, what, got, want);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_result   r;
        t_bus_beat nb;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent_beats++;
                if (predict_pins(beat_on_bus, r))
                    working_beats++;
                busy_refusals += r.rejected;
                seq_dones += r.done;
                pin_results_q.push_back(r);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bus_beats_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
                    nb = bus_beats_q.pop_front();
                    beat_on_bus = nb;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(InDataW-ByteW-1){1'b0}}, nb.sda, nb.data};
                    s_axis_tuser <= nb.kind;
                    s_axis_tlast <= nb.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (pin_results_q.size() == 0) begin
                    flag_mismatch("beat with nothing expected", got, 0);
                end else begin
                    want = pin_results_q.pop_front();
                    if (got.scl_level !== want.scl_level)
                        flag_mismatch("scl_level", got.scl_level, want.scl_level);
                    if (got.sda_low !== want.sda_low)
                        flag_mismatch("sda_low", got.sda_low, want.sda_low);
                    if (got.busy !== want.busy)
                        flag_mismatch("busy", got.busy, want.busy);
                    if (got.done !== want.done)
                        flag_mismatch("done", got.done, want.done);
                    if (got.ack_seen !== want.ack_seen)
                        flag_mismatch("ack_seen", got.ack_seen, want.ack_seen);
                    if (got.read_data !== want.read_data)
                        flag_mismatch("read_data", got.read_data, want.read_data);
                    if (got.rejected !== want.rejected)
                        flag_mismatch("rejected", got.rejected, want.rejected);
                end
                checked_beats++;
            end
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IdlePct);
        end
    end

    // long receiver hold-off, so the output stage fills and input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_given <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_given < hold_asked) begin
            hold_given <= hold_given + 1;
            hold_left <= HoldCycles;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LimitCycles) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, pin_results_q.size());
            $display("** i2c_bit_level_master: FAILED **");
            $finish;
        end
    end

    function automatic logic pick_sda(int mode);
        return (mode == SdaRand) ? logic'($urandom_range(1)) : logic'(mode);
    endfunction

    task automatic set_scl_gap(logic [DelayW-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        scl_gap_shadow = v;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (bus_beats_q.size() != 0 || s_axis_tvalid || pin_results_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // issue one command, then feed ticks while the sequence runs;
    // noise is the percentage of ticks replaced by a random kind
    task automatic run_cmd(logic [KindW-1:0] kind, logic [ByteW-1:0] data, logic last,
                           int sda_mode, int noise);
        t_bus_beat b;
        b.kind = kind;
        b.data = data;
        b.last = last;
        b.sda = pick_sda(sda_mode);
        bus_beats_q.push_back(b);
        forever begin
            @(negedge i_clk);
            if (seq_step == ST_IDLE && bus_beats_q.size() == 0 && !s_axis_tvalid)
                break;
            if (seq_step != ST_IDLE && bus_beats_q.size() < 2) begin
                b.data = ByteW'($urandom);
                b.last = 1'($urandom_range(1));
                b.sda = pick_sda(sda_mode);
                b.kind = ($urandom_range(99) < noise) ? KindW'($urandom_range(7))
                                                      : KindW'(K_TICK);
                bus_beats_q.push_back(b);
            end
        end
    endtask

    task automatic random_txn();
        int nw, nr;
        if ($urandom_range(99) < 15) begin
            run_cmd(KindW'($urandom_range(K_START, K_STOP)), ByteW'($urandom),
                    1'($urandom_range(1)), SdaRand, 5);
            return;
        end
        run_cmd(K_START, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 3);
        nw = $urandom_range(3);
        repeat (nw) run_cmd(K_WRITE, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 3);
        if ($urandom_range(1)) begin
            nr = $urandom_range(1, 3);
            for (int i = 1; i <= nr; i++)
                run_cmd(K_READ, ByteW'($urandom), i == nr, SdaRand, 3);
        end else begin
            run_cmd(K_STOP, ByteW'($urandom), 1'($urandom_range(1)), SdaRand, 3);
        end
    endtask

    initial begin
        t_bus_beat b;
        int phase;
        seq_step = ST_IDLE;
        seq_op = K_TICK;
        seq_shift = '0;
        seq_bits = '0;
        seq_wait = '0;
        scl_gap_shadow = '0;
        seq_scl = 1'b1;
        seq_sda_low = 1'b0;
        seq_ack = 1'b0;
        seq_last = 1'b0;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks including the spare kinds, extreme bytes,
        // NACK and ACK, read with ACK and with NACK plus stop, commands while busy
        set_scl_gap('0);
        @(negedge i_clk);
        for (int k = 0; k < 2 ** KindW; k++) begin
            if (k >= K_START && k <= K_STOP)
                continue;
            b.kind = KindW'(k);
            b.data = 8'hFF;
            b.last = 1'b1;
            b.sda = 1'b1;
            bus_beats_q.push_back(b);
        end
        drain();
        run_cmd(K_START, 8'hFF, 1'b1, SdaHigh, 0);
        run_cmd(K_WRITE, 8'h00, 1'b0, SdaLow, 0);
        run_cmd(K_WRITE, 8'hA5, 1'b0, SdaRand, 40);
        run_cmd(K_READ, 8'h00, 1'b0, SdaHigh, 0);
        run_cmd(K_READ, 8'hFF, 1'b1, SdaLow, 0);
        run_cmd(K_STOP, 8'h00, 1'b0, SdaRand, 0);
        drain();
        set_scl_gap(8'd1);
        run_cmd(K_START, 8'h5A, 1'b0, SdaLow, 0);
        run_cmd(K_STOP, 8'hFF, 1'b1, SdaRand, 0);

        phase = 0;
        while (sent_beats < ItemBudget) begin
            drain();
            case (phase % 5)
                0: set_scl_gap('0);
                1: set_scl_gap(8'd1);
                2: set_scl_gap(8'd2);
                3: set_scl_gap(DelayW'($urandom_range(3, 7)));
                default: set_scl_gap(DelayW'($urandom_range(3)));
            endcase
            @(negedge i_clk);
            calm = (phase == 2);
            if (phase == 1)
                hold_asked++;
            random_txn();
            phase++;
        end

        // slowest bus setting, a stop on its own
        drain();
        calm = 1'b0;
        set_scl_gap(8'hFF);
        run_cmd(K_STOP, ByteW'($urandom), 1'b0, SdaRand, 0);
        drain();

        $display("run covered %0d beats, %0d doing bus work, over %0d random phases, SCL gap 0 to 255",
                 sent_beats, working_beats, phase);
        $display("%0d sequences finished, %0d commands refused while busy, %0d beats checked",
                 seq_dones, busy_refusals, checked_beats);
        if (mismatches == 0)
            $display("** i2c_bit_level_master: PASSED **");
        else
            $display("** i2c_bit_level_master: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/i2cm_pkg.sv
sv/i2cm_seq.sv
sv/i2cm_obuf.sv
sv/i2c_bit_level_master.sv
tb/i2c_bit_level_master_tb.sv
